// ===== hdl/motorola_turnout_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// motorola turnout decoder assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MOTOROLA_TURNOUT_DECODER_TOP_MACROS_SVH
`define MOTOROLA_TURNOUT_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define MTD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MTD_ASSERT_ALWAYS(lbl, expr, msg)
`define MTD_ASSERT_IMPL(lbl, ante, cons, msg)
`define MTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtd_pkg
// types, constants and helpers shared by the turnout decoder modules
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TICK_WIDTH  = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;

  localparam logic [4:0] LAST_BIT     = 5'd17;
  localparam logic [4:0] FUNC_LSB     = 5'd8;
  localparam logic [4:0] DATA_LSB     = 5'd10;
  localparam logic [1:0] SAMPLE_DELAY = 2'd3;
  localparam logic [6:0] LOW_LIMIT    = 7'd120;

  localparam logic [7:0] ADDR_RESET    = 8'd127;
  localparam logic [2:0] SWITCH_RESET  = 3'd7;
  localparam logic [15:0] PULSE_RESET  = 16'd20000;
  localparam logic [15:0] LOCK_RESET   = 16'd20000;

  typedef enum logic [1:0] {
    REG_ADDRESS = 2'd0,
    REG_SWITCH  = 2'd1,
    REG_PULSE   = 2'd2,
    REG_LOCKOUT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]            address;
    logic [2:0]            switches;
    logic [TICK_WIDTH-1:0] pulse_ticks;
    logic [TICK_WIDTH-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic pkt_b;
    logic pkt_a;
    logic waiting;
    logic start;
  } rx_t;

  typedef struct packed {
    logic coil_straight;
    logic coil_diverge;
    logic pulse_active;
    logic lockout_active;
    logic address_valid;
    logic function_set;
  } result_t;

  // each bit of the turnout number becomes a pair of equal bits
  function automatic logic [7:0] pair_code(input logic [2:0] num);
    return {2'b00, num[2], num[2], num[1], num[1], num[0], num[0]};
  endfunction

endpackage

// ===== hdl/motorola_turnout_decoder_top.sv =====
// ----------------------------------------------------------------------------
// motorola_turnout_decoder_top
// accessory packet decoder driving a pair of turnout coils
// ----------------------------------------------------------------------------
// One sample tick is taken per clock cycle while in_stall is low. Each
// accepted item updates the receiver, the pair check and the coil timers,
// and its result (the state after that tick) is registered in the output
// register, or in the skid stage while the output is stalled. A skid stage
// behind the output register holds one more result, so in_stall rises only
// once two results are waiting. Configuration writes are always taken
// (cfg_ready is high) and should be made while no item is in flight.
// ----------------------------------------------------------------------------
module motorola_turnout_decoder_top import mtd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_rising_edge,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_coil_straight,
  output logic        out_coil_diverge,
  output logic        out_pulse_active,
  output logic        out_lockout_active,
  output logic        out_address_valid,
  output logic        out_function_set,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  result_t core_res;
  result_t buf_res;
  logic    step;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address       <= ADDR_RESET;
      cfg_r.switches      <= SWITCH_RESET;
      cfg_r.pulse_ticks   <= PULSE_RESET;
      cfg_r.lockout_ticks <= LOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ADDRESS: cfg_r.address       <= cfg_data[7:0];
        REG_SWITCH:  cfg_r.switches      <= cfg_data[2:0];
        REG_PULSE:   cfg_r.pulse_ticks   <= cfg_data[TICK_WIDTH-1:0];
        REG_LOCKOUT: cfg_r.lockout_ticks <= cfg_data[TICK_WIDTH-1:0];
        default:     cfg_r               <= cfg_r;
      endcase
    end
  end

  mtd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rising_edge (in_rising_edge),
    .line_level  (in_line_level),
    .cfg         (cfg_r),
    .res         (core_res)
  );

  mtd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_res    (core_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (buf_res)
  );

  assign out_coil_straight  = buf_res.coil_straight;
  assign out_coil_diverge   = buf_res.coil_diverge;
  assign out_pulse_active   = buf_res.pulse_active;
  assign out_lockout_active = buf_res.lockout_active;
  assign out_address_valid  = buf_res.address_valid;
  assign out_function_set   = buf_res.function_set;

endmodule

// ===== hdl/mtd_core.sv =====
// ----------------------------------------------------------------------------
// mtd_core
// packet receiver, pair check and coil timers, one sample tick per item
// ----------------------------------------------------------------------------
`include "motorola_turnout_decoder_top_macros.svh"

module mtd_core import mtd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  logic    rising_edge,
  input  logic    line_level,
  input  cfg_t    cfg,
  output result_t res
);

  rx_t                    rx_r, rx_nxt;
  logic [1:0]             delay_r, delay_nxt;
  logic [4:0]             bitpos_r, bitpos_nxt;
  logic [7:0]             addr_a_r, addr_a_nxt, addr_b_r, addr_b_nxt;
  logic [1:0]             func_a_r, func_a_nxt, func_b_r, func_b_nxt;
  logic [7:0]             data_a_r, data_a_nxt, data_b_r, data_b_nxt;
  logic [6:0]             low_r, low_nxt;
  logic                   pulse_r, pulse_nxt, lock_r, lock_nxt;
  logic                   straight_r, straight_nxt, diverge_r, diverge_nxt;
  logic [COUNT_WIDTH-1:0] pcount_r, pcount_nxt, lcount_r, lcount_nxt;
  logic                   avalid_r, avalid_nxt, fset_r, fset_nxt;

  logic       tick_ok;
  logic       pair_match;
  logic [4:0] func_ofs;
  logic [4:0] data_ofs;

  always_comb begin
    rx_nxt       = rx_r;
    delay_nxt    = delay_r;
    bitpos_nxt   = bitpos_r;
    addr_a_nxt   = addr_a_r;
    addr_b_nxt   = addr_b_r;
    func_a_nxt   = func_a_r;
    func_b_nxt   = func_b_r;
    data_a_nxt   = data_a_r;
    data_b_nxt   = data_b_r;
    low_nxt      = low_r;
    pulse_nxt    = pulse_r;
    lock_nxt     = lock_r;
    straight_nxt = straight_r;
    diverge_nxt  = diverge_r;
    pcount_nxt   = pcount_r;
    lcount_nxt   = lcount_r;
    avalid_nxt   = avalid_r;
    fset_nxt     = fset_r;
    tick_ok      = 1'b1;
    pair_match   = 1'b0;

    // edge handling
    if (rising_edge) begin
      if (rx_r == '0) begin
        rx_nxt         = '0;
        rx_nxt.start   = 1'b1;
        rx_nxt.waiting = 1'b1;
        rx_nxt.pkt_a   = 1'b1;
        bitpos_nxt     = '0;
      end else begin
        rx_nxt.waiting = 1'b1;
      end
      low_nxt   = '0;
      delay_nxt = '0;
    end

    // field offsets of the bit about to be stored
    func_ofs = bitpos_nxt - FUNC_LSB;
    data_ofs = bitpos_nxt - DATA_LSB;

    // coil pulse and lockout
    if (pulse_nxt) begin
      if (CMP_WIDTH'(pcount_r) > CMP_WIDTH'(cfg.pulse_ticks)) begin
        pulse_nxt    = 1'b0;
        straight_nxt = 1'b0;
        diverge_nxt  = 1'b0;
        lock_nxt     = 1'b1;
        lcount_nxt   = '0;
      end else begin
        pcount_nxt = COUNT_WIDTH'(pcount_r + 1'b1);
      end
    end
    if (lock_nxt) begin
      if (CMP_WIDTH'(lcount_nxt) > CMP_WIDTH'(cfg.lockout_ticks)) begin
        lock_nxt = 1'b0;
      end else begin
        lcount_nxt = COUNT_WIDTH'(lcount_nxt + 1'b1);
      end
    end

    // bit sampling
    if (rx_nxt.waiting) begin
      delay_nxt = delay_nxt + 2'd1;
      if (delay_nxt == SAMPLE_DELAY) begin
        rx_nxt.waiting = 1'b0;
        if (bitpos_nxt < FUNC_LSB) begin
          if (rx_nxt.pkt_a) addr_a_nxt[bitpos_nxt[2:0]] = line_level;
          if (rx_nxt.pkt_b) addr_b_nxt[bitpos_nxt[2:0]] = line_level;
        end else if (bitpos_nxt < DATA_LSB) begin
          if (rx_nxt.pkt_a) func_a_nxt[func_ofs[0]] = line_level;
          if (rx_nxt.pkt_b) func_b_nxt[func_ofs[0]] = line_level;
        end else if (bitpos_nxt <= LAST_BIT) begin
          if (rx_nxt.pkt_a) data_a_nxt[data_ofs[2:0]] = line_level;
          if (rx_nxt.pkt_b) data_b_nxt[data_ofs[2:0]] = line_level;
        end
        if (bitpos_nxt < LAST_BIT) begin
          bitpos_nxt = bitpos_nxt + 5'd1;
        end else if (rx_nxt.pkt_a) begin
          rx_nxt.pkt_a = 1'b0;
          rx_nxt.pkt_b = 1'b1;
          bitpos_nxt   = '0;
        end else if (rx_nxt.pkt_b) begin
          // pair check
          pair_match = (addr_a_nxt != '0) && (func_a_nxt == func_b_nxt) &&
                       (data_a_nxt == data_b_nxt) && (addr_a_nxt == addr_b_nxt);
          if (!pair_match) begin
            avalid_nxt = 1'b0;
            rx_nxt     = '0;
            tick_ok    = 1'b0;
          end else if (addr_b_nxt != cfg.address) begin
            rx_nxt  = '0;
            tick_ok = 1'b0;
          end else begin
            avalid_nxt = 1'b1;
            fset_nxt   = (func_b_nxt != '0);
            if ((data_b_nxt == pair_code(~cfg.switches)) && !lock_nxt && !pulse_nxt) begin
              pulse_nxt    = 1'b1;
              pcount_nxt   = '0;
              diverge_nxt  = fset_nxt;
              straight_nxt = !fset_nxt;
            end
            rx_nxt.done = 1'b1;
          end
        end
      end
    end

    // long low resets the receiver
    if (tick_ok && !line_level) begin
      if (low_nxt < LOW_LIMIT) begin
        low_nxt = low_nxt + 7'd1;
      end else begin
        low_nxt = '0;
        rx_nxt  = '0;
      end
    end
  end

  assign res.coil_straight  = straight_nxt;
  assign res.coil_diverge   = diverge_nxt;
  assign res.pulse_active   = pulse_nxt;
  assign res.lockout_active = lock_nxt;
  assign res.address_valid  = avalid_nxt;
  assign res.function_set   = fset_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r       <= '0;
      delay_r    <= '0;
      bitpos_r   <= '0;
      addr_a_r   <= '0;
      addr_b_r   <= '0;
      func_a_r   <= '0;
      func_b_r   <= '0;
      data_a_r   <= '0;
      data_b_r   <= '0;
      low_r      <= '0;
      pulse_r    <= 1'b0;
      lock_r     <= 1'b0;
      straight_r <= 1'b0;
      diverge_r  <= 1'b0;
      pcount_r   <= '0;
      lcount_r   <= '0;
      avalid_r   <= 1'b0;
      fset_r     <= 1'b0;
    end else if (step) begin
      rx_r       <= rx_nxt;
      delay_r    <= delay_nxt;
      bitpos_r   <= bitpos_nxt;
      addr_a_r   <= addr_a_nxt;
      addr_b_r   <= addr_b_nxt;
      func_a_r   <= func_a_nxt;
      func_b_r   <= func_b_nxt;
      data_a_r   <= data_a_nxt;
      data_b_r   <= data_b_nxt;
      low_r      <= low_nxt;
      pulse_r    <= pulse_nxt;
      lock_r     <= lock_nxt;
      straight_r <= straight_nxt;
      diverge_r  <= diverge_nxt;
      pcount_r   <= pcount_nxt;
      lcount_r   <= lcount_nxt;
      avalid_r   <= avalid_nxt;
      fset_r     <= fset_nxt;
    end
  end

  `MTD_ASSERT_ALWAYS(a_one_coil, !(straight_r && diverge_r), "both coils driven")
  `MTD_ASSERT_IMPL(a_coil_in_pulse, straight_r || diverge_r, pulse_r, "coil on outside pulse")
  `MTD_ASSERT_ALWAYS(a_pulse_lock_excl, !(pulse_r && lock_r), "pulse and lockout overlap")
  `MTD_ASSERT_ALWAYS(a_bitpos_range, bitpos_r <= LAST_BIT, "bit position out of range")

endmodule

// ===== hdl/mtd_out_buf.sv =====
// ----------------------------------------------------------------------------
// mtd_out_buf
// result register with a skid stage so the input side keeps moving
// ----------------------------------------------------------------------------
`include "motorola_turnout_decoder_top_macros.svh"

module mtd_out_buf import mtd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_res_r;
  result_t skid_res_r;
  logic    accept;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (accept) begin
        skid_valid_r <= 1'b1;
        skid_res_r   <= in_res;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      out_res_r    <= skid_res_r;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        out_res_r <= in_res;
      end
    end
  end

  `MTD_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r, "skid item with empty output")
  `MTD_ASSERT_NEXT(a_skid_fill, out_valid_r && out_stall && accept, skid_valid_r,
                   "stalled item not parked")

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the turnout decoder: it drives sample ticks made of
// coded packet pairs, broken pairs and line noise under the reset settings
// and one random setting, predicts the coil and flag state after every tick
// and compares each result item against that prediction with random idling
// on both sides
module tb_top;
  import mtd_pkg::*;

  class coil_scoreboard;
    cfg_t cfg;
    rx_t rx;
    logic [7:0] delay;
    logic [4:0] bit_pos;
    logic [7:0] addr [2];
    logic [1:0] func [2];
    logic [7:0] data [2];
    logic [6:0] low_cnt;
    bit pulse_on, lock_on, straight, diverge, addr_ok, func_ok;
    logic [COUNT_WIDTH-1:0] pulse_cnt, lock_cnt;
    result_t expected_states[$];
    int errors;

    function new();
      cfg = '{address: ADDR_RESET, switches: SWITCH_RESET,
              pulse_ticks: PULSE_RESET, lockout_ticks: LOCK_RESET};
      rx = '0;
      delay = '0;
      bit_pos = '0;
      for (int i = 0; i < 2; i++) begin
        addr[i] = '0;
        func[i] = '0;
        data[i] = '0;
      end
      low_cnt = '0;
      {pulse_on, lock_on, straight, diverge, addr_ok, func_ok} = '0;
      pulse_cnt = '0;
      lock_cnt = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_ADDRESS: cfg.address = val[7:0];
        REG_SWITCH:  cfg.switches = val[2:0];
        REG_PULSE:   cfg.pulse_ticks = val;
        REG_LOCKOUT: cfg.lockout_ticks = val;
      endcase
    endfunction

    // each bit of the turnout number doubled into a bit pair
    function logic [7:0] coded_turnout();
      logic [2:0] num;
      logic [7:0] code;
      num = 3'd7 - cfg.switches;
      code = '0;
      for (int i = 0; i < 3; i++) begin
        code[2*i] = num[i];
        code[2*i+1] = num[i];
      end
      return code;
    endfunction

    function void store_sample(int s, bit lvl);
      if (bit_pos < FUNC_LSB) addr[s][bit_pos[2:0]] = lvl;
      else if (bit_pos < DATA_LSB) func[s][bit_pos - FUNC_LSB] = lvl;
      else if (bit_pos <= LAST_BIT) data[s][bit_pos - DATA_LSB] = lvl;
    endfunction

    function bit check_pair();
      if (addr[0] != 0 && func[0] == func[1] && data[0] == data[1] && addr[0] == addr[1]) begin
        if (addr[1] != cfg.address) begin
          rx = '0;
          return 1'b0;
        end
        addr_ok = 1'b1;
        func_ok = (func[1] != 0);
        if (data[1] == coded_turnout() && !lock_on && !pulse_on) begin
          pulse_on = 1'b1;
          pulse_cnt = '0;
          straight = !func_ok;
          diverge = func_ok;
        end
        rx.done = 1'b1;
        return 1'b1;
      end
      addr_ok = 1'b0;
      rx = '0;
      return 1'b0;
    endfunction

    // returns 0 when a pair check reset the receiver
    function bit run_tick(bit lvl);
      if (pulse_on) begin
        if (pulse_cnt > cfg.pulse_ticks) begin
          pulse_on = 1'b0;
          straight = 1'b0;
          diverge = 1'b0;
          lock_on = 1'b1;
          lock_cnt = '0;
        end else begin
          pulse_cnt++;
        end
      end
      if (lock_on) begin
        if (lock_cnt > cfg.lockout_ticks) lock_on = 1'b0;
        else lock_cnt++;
      end
      if (rx.waiting) begin
        delay++;
        if (delay >= SAMPLE_DELAY) begin
          rx.waiting = 1'b0;
          if (rx.pkt_a) store_sample(0, lvl);
          if (rx.pkt_b) store_sample(1, lvl);
          if (bit_pos < LAST_BIT) begin
            bit_pos++;
          end else if (rx.pkt_a) begin
            rx.pkt_a = 1'b0;
            rx.pkt_b = 1'b1;
            bit_pos = '0;
          end else if (rx.pkt_b) begin
            if (!check_pair()) return 1'b0;
          end
        end
      end
      return 1'b1;
    endfunction

    function void note_tick(bit rise, bit lvl);
      if (rise) begin
        if (rx == '0) begin
          rx = '0;
          rx.start = 1'b1;
          rx.waiting = 1'b1;
          rx.pkt_a = 1'b1;
          bit_pos = '0;
        end else begin
          rx.waiting = 1'b1;
        end
        low_cnt = '0;
        delay = '0;
      end
      if (run_tick(lvl) && !lvl) begin
        if (low_cnt < LOW_LIMIT) begin
          low_cnt++;
        end else begin
          low_cnt = '0;
          rx = '0;
        end
      end
      expected_states.push_back('{coil_straight: straight, coil_diverge: diverge,
                                  pulse_active: pulse_on, lockout_active: lock_on,
                                  address_valid: addr_ok, function_set: func_ok});
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, got %0b", name, want, got);
        errors++;
      end
    endfunction

    function void check_state(result_t got);
      result_t want;
      if (expected_states.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      want = expected_states.pop_front();
      compare_bit("coil_straight", want.coil_straight, got.coil_straight);
      compare_bit("coil_diverge", want.coil_diverge, got.coil_diverge);
      compare_bit("pulse_active", want.pulse_active, got.pulse_active);
      compare_bit("lockout_active", want.lockout_active, got.lockout_active);
      compare_bit("address_valid", want.address_valid, got.address_valid);
      compare_bit("function_set", want.function_set, got.function_set);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_rising_edge;
  logic        in_line_level;
  logic        out_valid;
  logic        out_stall;
  logic        out_coil_straight;
  logic        out_coil_diverge;
  logic        out_pulse_active;
  logic        out_lockout_active;
  logic        out_address_valid;
  logic        out_function_set;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  result_t seen;
  coil_scoreboard sb = new();
  int sent = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;

  motorola_turnout_decoder_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rising_edge     (in_rising_edge),
    .in_line_level      (in_line_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_coil_straight  (out_coil_straight),
    .out_coil_diverge   (out_coil_diverge),
    .out_pulse_active   (out_pulse_active),
    .out_lockout_active (out_lockout_active),
    .out_address_valid  (out_address_valid),
    .out_function_set   (out_function_set),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  assign seen = {out_coil_straight, out_coil_diverge, out_pulse_active,
                 out_lockout_active, out_address_valid, out_function_set};

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_rising_edge, in_line_level);
      if (out_valid && !out_stall) sb.check_state(seen);
    end
  end

  // result side
  initial begin
    int hold;
    int taken;
    taken = 0;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = out_steady ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
      @(negedge clk);
      taken++;
      if (taken % 40 == 0) out_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_tick(input bit rise, input bit lvl);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rising_edge <= rise;
    in_line_level <= lvl;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // edge, one tick, then the tick whose level is sampled
  task automatic send_bit(input bit b);
    send_tick(1'b1, $urandom_range(0, 3) != 0);
    send_tick(1'b0, 1'($urandom));
    send_tick(1'b0, b);
    if ($urandom_range(0, 9) >= 7) repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'($urandom));
  endtask

  task automatic send_long_low();
    repeat ($urandom_range(121, 124)) send_tick(1'b0, 1'b0);
  endtask

  // input idles while the block drains
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_states.size() != 0) @(negedge clk);
  endtask

  task automatic send_frame(input bit good);
    logic [7:0] a, d;
    logic [1:0] f;
    logic [17:0] pa, pb;
    int style, cut, k;
    in_steady = ($urandom_range(0, 3) == 0);
    style = good ? 0 : $urandom_range(0, 9);
    if (style == 9) begin
      repeat ($urandom_range(2, 8)) send_tick(1'($urandom), 1'($urandom));
      send_long_low();
      return;
    end
    if (good || $urandom_range(0, 9) < 7) a = sb.cfg.address;
    else a = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
    d = (good || $urandom_range(0, 9) < 7) ? sb.coded_turnout() : 8'($urandom);
    f = 2'($urandom);
    pa = {d, f, a};
    pb = pa;
    if (style == 8) begin
      k = $urandom_range(0, 17);
      pb[k] = ~pb[k];
    end
    if (style == 7) begin
      cut = $urandom_range(1, 35);
      for (k = 0; k < cut; k++) send_bit(k < 18 ? pa[k] : pb[k-18]);
      send_long_low();
      return;
    end
    for (k = 0; k < 18; k++) send_bit(pa[k]);
    for (k = 0; k < 18; k++) send_bit(pb[k]);
    // extra edges re-check the pair while it stays latched
    repeat ($urandom_range(0, 3)) send_bit(pb[17]);
    if (sb.rx != '0) begin
      if ($urandom_range(0, 3) == 0) send_long_low();
      else send_bit(~pb[17]);
    end
    repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'b1);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] a, input logic [2:0] sw,
                               input logic [15:0] pulse, input logic [15:0] lock);
    wait_drained();
    repeat (4) @(negedge clk);
    write_reg(REG_ADDRESS, {8'($urandom), a});
    write_reg(REG_SWITCH, {13'($urandom), sw});
    write_reg(REG_PULSE, pulse);
    write_reg(REG_LOCKOUT, lock);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase();
    int start;
    start = sent;
    while (sent - start < 70) begin
      if ($urandom_range(0, 9) == 0) wait_drained();
      send_frame(1'b0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rising_edge = 1'b0;
    in_line_level = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ADDRESS;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: a clean pair, then every edge and level combination
    send_frame(1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_long_low();

    // short pulse and lockout so both phases run to their end
    apply_setting(8'($urandom_range(1, 255)), 3'($urandom),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
    run_phase();

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
